### hdl/hff_pkg.sv
// Shared types, character codes and the control store for the hex field formatter.
// No dependencies; the layout unit, the top level and the testbench import it.
`default_nettype none

package hff_pkg;

  // Character counts: a run never exceeds 64 characters.
  localparam int CNT_W = 7;

  // Largest precision that is honored.
  localparam logic [5:0] PREC_CAP = 6'd62;

  // ASCII codes used to build the field.
  localparam logic [7:0] CH_SPACE   = 8'h20;
  localparam logic [7:0] CH_ZERO    = 8'h30;
  localparam logic [7:0] CH_LOWER_A = 8'h61;
  localparam logic [7:0] CH_UPPER_A = 8'h41;
  localparam logic [7:0] CH_LOWER_X = 8'h78;
  localparam logic [7:0] CH_UPPER_X = 8'h58;

  // Program counter of the sequencer and its step addresses.
  typedef logic [2:0] step_t;
  localparam int    UC_STEPS = 8;
  localparam step_t UC_IDLE  = 3'd0;
  localparam step_t UC_SETUP = 3'd1;
  localparam step_t UC_LSP   = 3'd2;
  localparam step_t UC_P0    = 3'd3;
  localparam step_t UC_PX    = 3'd4;
  localparam step_t UC_ZER   = 3'd5;
  localparam step_t UC_DIG   = 3'd6;
  localparam step_t UC_RSP   = 3'd7;

  // What a step does with the datapath.
  typedef enum logic [2:0] {
    OP_WAIT  = 3'd0,
    OP_SETUP = 3'd1,
    OP_SPACE = 3'd2,
    OP_ZERO  = 3'd3,
    OP_X     = 3'd4,
    OP_DIGIT = 3'd5
  } uc_op_t;

  // Which count register sets the repeat count of a step.
  typedef enum logic [2:0] {
    SRC_NONE = 3'd0,
    SRC_LSP  = 3'd1,
    SRC_PFX  = 3'd2,
    SRC_ZER  = 3'd3,
    SRC_DIG  = 3'd4,
    SRC_RSP  = 3'd5
  } cnt_src_t;

  typedef struct packed {
    uc_op_t   op;
    cnt_src_t src;
  } uc_word_t;

  // Field layout: repeat counts of each section of the run.
  typedef struct packed {
    logic             pfx;
    logic [CNT_W-1:0] lsp;
    logic [CNT_W-1:0] zcnt;
    logic [CNT_W-1:0] ndig;
    logic [CNT_W-1:0] rsp;
  } hff_layout_t;

  // Control store: one word per step, in the order the field is written.
  function automatic uc_word_t uc_rom(input step_t addr);
    uc_word_t w;
    unique case (addr)
      UC_IDLE:  w = '{op: OP_WAIT,  src: SRC_NONE};
      UC_SETUP: w = '{op: OP_SETUP, src: SRC_NONE};
      UC_LSP:   w = '{op: OP_SPACE, src: SRC_LSP};
      UC_P0:    w = '{op: OP_ZERO,  src: SRC_PFX};
      UC_PX:    w = '{op: OP_X,     src: SRC_PFX};
      UC_ZER:   w = '{op: OP_ZERO,  src: SRC_ZER};
      UC_DIG:   w = '{op: OP_DIGIT, src: SRC_DIG};
      UC_RSP:   w = '{op: OP_SPACE, src: SRC_RSP};
      default:  w = '{op: OP_WAIT,  src: SRC_NONE};
    endcase
    return w;
  endfunction

endpackage

`default_nettype wire

### hdl/hex_field_formatter_unit.sv
// Top level of the hex field formatter: input capture, microcoded sequencer, output register.
// Depends on hff_pkg and instantiates hff_layout.
//
// Usage: drive the value and the %x options on the in_ ports and raise start; the item
// is taken at a rising edge where start is high and busy is low. busy stays high until
// the last character of the item has been produced.
// The formatted field leaves one character per cycle on out_char, each marked by
// out_strobe for exactly one cycle; out_last_char flags the final character of a run.
// An item whose field is empty (zero value, precision zero, no prefix, no width)
// produces no strobe at all.
// After the accepting edge, a setup step loads the layout, and the first sequencer step
// then puts the first character into the output register.
// busy stays high through the setup step and every output step of an item, so a new
// item is taken only once the last character of the previous one has been produced.
// Reset (rst_n low, synchronous) returns the sequencer to its wait step and drops the
// strobe. The receiver cannot stall: every strobed character is taken as it appears.
`default_nettype none

module hex_field_formatter_unit #(
  parameter int VALUE_BITS = 64,
  parameter int MAX_WIDTH  = 64
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  start,
  output logic                       busy,
  input  wire logic [VALUE_BITS-1:0] in_value,
  input  wire logic                  in_upper_case,
  input  wire logic                  in_alt_form,
  input  wire logic                  in_precision_given,
  input  wire logic [5:0]            in_precision,
  input  wire logic [6:0]            in_width,
  input  wire logic                  in_zero_pad,
  input  wire logic                  in_left_justify,
  output logic                       out_strobe,
  output logic [7:0]                 out_char,
  output logic                       out_last_char
);
  import hff_pkg::*;

  localparam int NIBS   = (VALUE_BITS + 3) / 4;
  localparam int NIB_IW = (NIBS > 1) ? $clog2(NIBS) : 1;
  localparam int EXT_W  = 4 << NIB_IW;

  // Captured item.
  logic [VALUE_BITS-1:0] value_r;
  logic                  upper_r;
  logic                  alt_r;
  logic                  pgiven_r;
  logic [5:0]            prec_r;
  logic [6:0]            width_r;
  logic                  zpad_r;
  logic                  left_r;

  // Sequencer state.
  step_t            pc_r, pc_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  hff_layout_t      lay, lay_r, lay_sel;
  uc_word_t         word;
  step_t            next_step;
  logic             emit;
  logic             cnt_last;

  // Datapath.
  logic [EXT_W-1:0]  val_ext;
  logic [NIB_IW-1:0] dig_idx;
  logic [3:0]        nib;
  logic [7:0]        dig_char;

  logic       out_strobe_r, out_strobe_nxt;
  logic [7:0] out_char_r, out_char_nxt;
  logic       out_last_r, out_last_nxt;

  function automatic logic [CNT_W-1:0] src_count(input hff_layout_t l, input cnt_src_t s);
    logic [CNT_W-1:0] c;
    unique case (s)
      SRC_LSP:  c = l.lsp;
      SRC_PFX:  c = {{(CNT_W-1){1'b0}}, l.pfx};
      SRC_ZER:  c = l.zcnt;
      SRC_DIG:  c = l.ndig;
      SRC_RSP:  c = l.rsp;
      default:  c = '0;
    endcase
    return c;
  endfunction

  // Repeat count that a given step takes from the layout.
  function automatic logic [CNT_W-1:0] step_count(input hff_layout_t l, input step_t st);
    uc_word_t w;
    w = uc_rom(st);
    return src_count(l, w.src);
  endfunction

  hff_layout #(
    .VALUE_BITS (VALUE_BITS),
    .MAX_WIDTH  (MAX_WIDTH)
  ) u_layout (
    .value           (value_r),
    .alt_form        (alt_r),
    .precision_given (pgiven_r),
    .precision       (prec_r),
    .width           (width_r),
    .zero_pad        (zpad_r),
    .left_justify    (left_r),
    .layout          (lay)
  );

  assign busy = (pc_r != UC_IDLE);
  assign word = uc_rom(pc_r);

  // During setup the counts come straight from the layout unit.
  assign lay_sel = (pc_r == UC_SETUP) ? lay : lay_r;

  // Conditional jump: the next later step that has characters to give, else back to wait.
  always_comb begin
    next_step = UC_IDLE;
    for (int s = UC_STEPS - 1; s >= 0; s--) begin
      if ((3'(s) > pc_r) && (step_count(lay_sel, 3'(s)) != '0)) begin
        next_step = 3'(s);
      end
    end
  end

  assign cnt_last = (cnt_r == CNT_W'(1));

  // Step counter and repeat counter.
  always_comb begin
    pc_nxt  = pc_r;
    cnt_nxt = cnt_r;
    emit    = 1'b0;
    unique case (word.op)
      OP_WAIT: begin
        if (start) pc_nxt = UC_SETUP;
      end
      OP_SETUP: begin
        pc_nxt  = next_step;
        cnt_nxt = step_count(lay_sel, next_step);
      end
      OP_SPACE, OP_ZERO, OP_X, OP_DIGIT: begin
        emit = 1'b1;
        if (cnt_last) begin
          pc_nxt  = next_step;
          cnt_nxt = step_count(lay_sel, next_step);
        end else begin
          cnt_nxt = cnt_r - CNT_W'(1);
        end
      end
      default: begin
        pc_nxt = UC_IDLE;
      end
    endcase
  end

  // Digit select: the repeat counter walks from the top nibble down.
  assign val_ext = EXT_W'(value_r);
  assign dig_idx = NIB_IW'(cnt_r - CNT_W'(1));
  assign nib     = val_ext[dig_idx*4 +: 4];

  always_comb begin
    if (nib < 4'd10) begin
      dig_char = CH_ZERO + {4'd0, nib};
    end else if (upper_r) begin
      dig_char = CH_UPPER_A + {4'd0, nib} - 8'd10;
    end else begin
      dig_char = CH_LOWER_A + {4'd0, nib} - 8'd10;
    end
  end

  // Character for the current step.
  always_comb begin
    case (word.op)
      OP_SPACE: out_char_nxt = CH_SPACE;
      OP_X:     out_char_nxt = upper_r ? CH_UPPER_X : CH_LOWER_X;
      OP_DIGIT: out_char_nxt = dig_char;
      default:  out_char_nxt = CH_ZERO;
    endcase
  end

  assign out_strobe_nxt = emit;
  assign out_last_nxt   = emit && cnt_last && (next_step == UC_IDLE);

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pc_r         <= UC_IDLE;
      out_strobe_r <= 1'b0;
    end else begin
      pc_r         <= pc_nxt;
      out_strobe_r <= out_strobe_nxt;
    end
  end

  // Payload registers: item capture on a start transfer, layout at setup, count and output.
  always_ff @(posedge clk) begin
    if (start && !busy) begin
      value_r  <= in_value;
      upper_r  <= in_upper_case;
      alt_r    <= in_alt_form;
      pgiven_r <= in_precision_given;
      prec_r   <= in_precision;
      width_r  <= in_width;
      zpad_r   <= in_zero_pad;
      left_r   <= in_left_justify;
    end
    if (pc_r == UC_SETUP) lay_r <= lay;
    cnt_r      <= cnt_nxt;
    out_char_r <= out_char_nxt;
    out_last_r <= out_last_nxt;
  end

  assign out_strobe    = out_strobe_r;
  assign out_char      = out_char_r;
  assign out_last_char = out_last_r;

endmodule

`default_nettype wire

### hdl/hff_layout.sv
// Field layout unit: works out how many characters each section of the run gets.
// Depends on hff_pkg for the layout struct, the count width and the precision cap.
`default_nettype none

module hff_layout #(
  parameter int VALUE_BITS = 64,
  parameter int MAX_WIDTH  = 64
) (
  input  wire logic [VALUE_BITS-1:0] value,
  input  wire logic                  alt_form,
  input  wire logic                  precision_given,
  input  wire logic [5:0]            precision,
  input  wire logic [6:0]            width,
  input  wire logic                  zero_pad,
  input  wire logic                  left_justify,
  output hff_pkg::hff_layout_t       layout
);
  import hff_pkg::*;

  localparam int         NIBS    = (VALUE_BITS + 3) / 4;
  localparam int         EXT_W   = 4 * NIBS;
  localparam logic [6:0] WID_CAP = 7'(MAX_WIDTH);

  logic [EXT_W-1:0] val_ext;
  logic             vzero;
  logic [CNT_W-1:0] ndig_raw;
  logic [CNT_W-1:0] ndig;
  logic [5:0]       prec_eff;
  logic [CNT_W-1:0] pzeros;
  logic [CNT_W-1:0] total;
  logic [6:0]       wid;
  logic [CNT_W-1:0] pad;
  logic             zmode;
  logic             pfx;

  assign val_ext = EXT_W'(value);
  assign vzero   = (value == '0);

  // Digit count: position of the highest nonzero nibble, at least one digit.
  always_comb begin
    ndig_raw = CNT_W'(1);
    for (int k = 0; k < NIBS; k++) begin
      if (val_ext[4*k +: 4] != 4'd0) ndig_raw = CNT_W'(k + 1);
    end
  end

  // A zero value with an explicit precision of zero prints no digits.
  assign ndig = (vzero && precision_given && (precision == 6'd0)) ? '0 : ndig_raw;

  always_comb begin
    if (!precision_given) begin
      prec_eff = 6'd0;
    end else if (precision > PREC_CAP) begin
      prec_eff = PREC_CAP;
    end else begin
      prec_eff = precision;
    end
  end

  assign pzeros = (CNT_W'(prec_eff) > ndig) ? CNT_W'(prec_eff) - ndig : '0;
  assign pfx    = alt_form && !vzero;
  assign total  = ndig + pzeros + {{(CNT_W-2){1'b0}}, pfx, 1'b0};
  assign wid    = (width > WID_CAP) ? WID_CAP : width;
  assign pad    = (wid > total) ? wid - total : '0;

  // Zero padding goes after the prefix and only without precision or left justify.
  assign zmode = !precision_given && zero_pad && !left_justify;

  assign layout.pfx  = pfx;
  assign layout.lsp  = (!left_justify && !zmode) ? pad : '0;
  assign layout.zcnt = zmode ? (pad + pzeros) : pzeros;
  assign layout.ndig = ndig;
  assign layout.rsp  = left_justify ? pad : '0;

endmodule

`default_nettype wire

### hdl/hff_checker.sv
// Port-level checker for the hex field formatter, bound to the top level.
// Depends on the top level's port names only.
`default_nettype none

module hff_checker (
  input wire logic clk,
  input wire logic rst_n,
  input wire logic start,
  input wire logic busy,
  input wire logic out_strobe,
  input wire logic out_last_char
);

  // A start transfer always keeps the block busy in the next cycle.
  a_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy |=> busy)
    else $error("busy not raised after a start transfer");

  // Characters are only produced for an item in progress.
  a_strobe_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |-> $past(busy))
    else $error("character strobed without an item in progress");

  // A run is contiguous until its last character.
  a_run_contig: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe && !out_last_char |=> out_strobe)
    else $error("gap inside a character run");

  // The last character coincides with the block being free again.
  a_last_free: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe && out_last_char |-> !busy)
    else $error("still busy when the last character is shown");

endmodule

bind hex_field_formatter_unit hff_checker u_hff_checker (.*);

`default_nettype wire

### tb/tb_hex_field_formatter_unit.sv
// Self-checking testbench for hex_field_formatter_unit: %x field formatting, one character per strobe.
// Depends on hff_pkg for the character codes and the precision cap; needs only the RTL.
`timescale 1ns / 100ps

module tb_hex_field_formatter_unit;
  import hff_pkg::*;

  localparam int MAX_WIDTH     = 64;
  localparam int QUIET_LIMIT   = 1000;
  localparam int SETTLE_CYCLES = 80;
  localparam int RANDOM_ITEMS  = 400;

  // One conversion request as it is driven on the in_ ports.
  typedef struct {
    logic [63:0] value;
    logic        upper_case;
    logic        alt_form;
    logic        prec_given;
    logic [5:0]  precision;
    logic [6:0]  fld_width;
    logic        zero_pad;
    logic        left_justify;
  } hex_req_t;

  // One character of a formatted field together with its end-of-run mark.
  typedef struct packed {
    logic [7:0] ch;
    logic       last;
  } fmt_char_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        start = 1'b0;
  logic        busy;
  logic [63:0] in_value = '0;
  logic        in_upper_case = 1'b0;
  logic        in_alt_form = 1'b0;
  logic        in_precision_given = 1'b0;
  logic [5:0]  in_precision = '0;
  logic [6:0]  in_width = '0;
  logic        in_zero_pad = 1'b0;
  logic        in_left_justify = 1'b0;
  logic        out_strobe;
  logic [7:0]  out_char;
  logic        out_last_char;

  fmt_char_t expected_chars[$];
  int        err_count = 0;
  int        quiet_cycles = 0;

  always #1 clk = ~clk;

  hex_field_formatter_unit dut (
    .clk                (clk),
    .rst_n              (rst_n),
    .start              (start),
    .busy               (busy),
    .in_value           (in_value),
    .in_upper_case      (in_upper_case),
    .in_alt_form        (in_alt_form),
    .in_precision_given (in_precision_given),
    .in_precision       (in_precision),
    .in_width           (in_width),
    .in_zero_pad        (in_zero_pad),
    .in_left_justify    (in_left_justify),
    .out_strobe         (out_strobe),
    .out_char           (out_char),
    .out_last_char      (out_last_char)
  );

  // Builds the expected character run of one request and queues it.
  function automatic void predict_hex_field(input hex_req_t r);
    int         prec;
    int         wid;
    int         pfx;
    int         ndig;
    int         pzeros;
    int         total;
    int         pad;
    int         i;
    logic [3:0] nib;
    logic [7:0] x_ch;
    logic [7:0] a_ch;
    logic [7:0] run[$];
    x_ch = r.upper_case ? CH_UPPER_X : CH_LOWER_X;
    a_ch = r.upper_case ? CH_UPPER_A : CH_LOWER_A;
    prec = r.prec_given ? int'(r.precision) : 0;
    if (prec > int'(PREC_CAP)) prec = int'(PREC_CAP);
    wid = (int'(r.fld_width) > MAX_WIDTH) ? MAX_WIDTH : int'(r.fld_width);
    pfx = (r.alt_form && r.value != 0) ? 2 : 0;
    ndig = 1;
    for (i = 1; i < 16; i++) begin
      if ((r.value >> (4 * i)) != 0) ndig = i + 1;
    end
    // A zero value with an explicit precision of zero prints no digits.
    if (r.value == 0 && r.prec_given && prec == 0) ndig = 0;
    pzeros = (prec > ndig) ? prec - ndig : 0;
    total = ndig + pzeros + pfx;
    pad = (wid > total) ? wid - total : 0;

    // Right-justified padding: zeros after the prefix, or spaces before it.
    if (pad > 0 && !r.left_justify) begin
      if (!r.prec_given && r.zero_pad) begin
        if (pfx != 0) begin
          run.push_back(CH_ZERO);
          run.push_back(x_ch);
          pfx = 0;
        end
        repeat (pad) run.push_back(CH_ZERO);
      end else begin
        repeat (pad) run.push_back(CH_SPACE);
      end
    end
    if (pfx != 0) begin
      run.push_back(CH_ZERO);
      run.push_back(x_ch);
    end
    repeat (pzeros) run.push_back(CH_ZERO);
    for (i = ndig - 1; i >= 0; i--) begin
      nib = r.value[4 * i +: 4];
      run.push_back((nib < 4'd10) ? 8'(CH_ZERO + nib) : 8'(a_ch + nib - 4'd10));
    end
    if (pad > 0 && r.left_justify) begin
      repeat (pad) run.push_back(CH_SPACE);
    end

    foreach (run[k]) begin
      expected_chars.push_back('{ch: run[k], last: (k == run.size() - 1)});
    end
  endfunction

  function automatic hex_req_t make_req(input logic [63:0] value, input logic upper,
                                        input logic alt, input logic prec_given,
                                        input logic [5:0] prec, input logic [6:0] wid,
                                        input logic zpad, input logic left);
    hex_req_t r;
    r.value = value;
    r.upper_case = upper;
    r.alt_form = alt;
    r.prec_given = prec_given;
    r.precision = prec;
    r.fld_width = wid;
    r.zero_pad = zpad;
    r.left_justify = left;
    return r;
  endfunction

  // Random request: digit counts spread evenly, mostly narrow fields, a few at the caps.
  function automatic hex_req_t random_req();
    hex_req_t r;
    int       nibbles;
    nibbles = $urandom_range(0, 16);
    r.value = {$urandom, $urandom};
    if (nibbles == 0) r.value = '0;
    else if (nibbles < 16) r.value = r.value & ((64'h1 << (4 * nibbles)) - 64'h1);
    r.upper_case = 1'($urandom_range(0, 1));
    r.alt_form = 1'($urandom_range(0, 1));
    r.prec_given = 1'($urandom_range(0, 1));
    r.precision = ($urandom_range(0, 9) == 0) ? 6'($urandom_range(0, 63))
                                              : 6'($urandom_range(0, 20));
    r.fld_width = ($urandom_range(0, 9) == 0) ? 7'($urandom_range(0, 127))
                                              : 7'($urandom_range(0, 24));
    r.zero_pad = 1'($urandom_range(0, 1));
    r.left_justify = 1'($urandom_range(0, 1));
    // Now and then force the no-digit corner: zero value with precision zero.
    if ($urandom_range(0, 11) == 0) begin
      r.value = '0;
      r.prec_given = 1'b1;
      r.precision = '0;
    end
    return r;
  endfunction

  // Drives one request and holds it until the block takes the transfer.
  task automatic send_item(input hex_req_t r);
    bit taken;
    @(negedge clk);
    start <= 1'b1;
    in_value <= r.value;
    in_upper_case <= r.upper_case;
    in_alt_form <= r.alt_form;
    in_precision_given <= r.prec_given;
    in_precision <= r.precision;
    in_width <= r.fld_width;
    in_zero_pad <= r.zero_pad;
    in_left_justify <= r.left_justify;
    taken = 1'b0;
    while (!taken) begin
      @(posedge clk);
      taken = !busy;
    end
    predict_hex_field(r);
  endtask

  // Drops start for a number of cycles between bursts.
  task automatic sender_gap(input int cycles);
    if (cycles > 0) begin
      @(negedge clk);
      start <= 1'b0;
      repeat (cycles) @(posedge clk);
    end
  endtask

  task automatic wait_all_received();
    while (expected_chars.size() != 0) @(posedge clk);
  endtask

  // Field extremes, every flag combination of interest and the saturation cases.
  task automatic test_directed_cases();
    send_item(make_req(64'h0, 1'b0, 1'b0, 1'b1, 6'd0, 7'd0, 1'b0, 1'b0));
    send_item(make_req(64'h0, 1'b1, 1'b1, 1'b1, 6'd0, 7'd0, 1'b1, 1'b0));
    send_item(make_req(64'h0, 1'b0, 1'b0, 1'b1, 6'd0, 7'd5, 1'b0, 1'b0));
    send_item(make_req(64'h0, 1'b0, 1'b0, 1'b0, 6'd0, 7'd0, 1'b0, 1'b0));
    send_item(make_req(64'h0, 1'b0, 1'b1, 1'b0, 6'd0, 7'd4, 1'b1, 1'b0));
    send_item(make_req(64'hFFFF_FFFF_FFFF_FFFF, 1'b0, 1'b0, 1'b0, 6'd0, 7'd0, 1'b0, 1'b0));
    send_item(make_req(64'hFFFF_FFFF_FFFF_FFFF, 1'b1, 1'b1, 1'b0, 6'd0, 7'd0, 1'b0, 1'b0));
    send_item(make_req(64'hAB_CDEF, 1'b1, 1'b1, 1'b0, 6'd0, 7'd12, 1'b1, 1'b0));
    send_item(make_req(64'hAB_CDEF, 1'b0, 1'b1, 1'b1, 6'd2, 7'd12, 1'b1, 1'b0));
    send_item(make_req(64'h1234, 1'b0, 1'b1, 1'b0, 6'd0, 7'd12, 1'b1, 1'b1));
    send_item(make_req(64'h5, 1'b0, 1'b1, 1'b1, 6'd62, 7'd0, 1'b0, 1'b0));
    send_item(make_req(64'h5, 1'b1, 1'b1, 1'b1, 6'd63, 7'd70, 1'b0, 1'b0));
    send_item(make_req(64'h1, 1'b0, 1'b0, 1'b0, 6'd0, 7'd127, 1'b0, 1'b0));
    send_item(make_req(64'h1, 1'b0, 1'b1, 1'b0, 6'd0, 7'd127, 1'b1, 1'b1));
    send_item(make_req(64'hF, 1'b0, 1'b1, 1'b0, 6'd0, 7'd64, 1'b1, 1'b0));
    send_item(make_req(64'h8000_0000_0000_0000, 1'b1, 1'b0, 1'b1, 6'd20, 7'd0, 1'b0, 1'b0));
    send_item(make_req(64'h10, 1'b0, 1'b0, 1'b0, 6'd0, 7'd1, 1'b0, 1'b0));
    send_item(make_req(64'h7, 1'b0, 1'b0, 1'b1, 6'd0, 7'd0, 1'b0, 1'b0));
    send_item(make_req(64'h0, 1'b0, 1'b1, 1'b0, 6'd0, 7'd3, 1'b0, 1'b1));
    send_item(make_req(64'h0, 1'b1, 1'b0, 1'b1, 6'd3, 7'd0, 1'b1, 1'b0));
    send_item(make_req(64'h0123_4567_89AB_CDEF, 1'b1, 1'b0, 1'b0, 6'd0, 7'd0, 1'b0, 1'b0));
    send_item(make_req(64'hFEDC_BA98_7654_3210, 1'b0, 1'b0, 1'b0, 6'd63, 7'd127, 1'b1, 1'b0));
    send_item(make_req(64'h5A, 1'b0, 1'b1, 1'b1, 6'd4, 7'd10, 1'b0, 1'b1));
    sender_gap(4);
  endtask

  // The sender holds off until every queued character has come back.
  task automatic test_drain_pause();
    repeat (6) send_item(random_req());
    sender_gap(1);
    wait_all_received();
    repeat (6) send_item(random_req());
  endtask

  // Random requests in bursts; a zero gap keeps start high across bursts.
  task automatic test_random_traffic(input int count);
    int sent;
    int burst;
    sent = 0;
    while (sent < count) begin
      burst = $urandom_range(1, 12);
      while (burst > 0 && sent < count) begin
        send_item(random_req());
        sent++;
        burst--;
      end
      if ($urandom_range(0, 3) != 0) sender_gap($urandom_range(1, 20));
    end
    sender_gap(1);
  endtask

  // Compares every strobed character with the oldest expectation.
  always @(posedge clk) begin : char_check
    fmt_char_t want;
    if (rst_n && out_strobe) begin
      if (expected_chars.size() == 0) begin
        $error("unexpected character: out_char=%h out_last_char=%b", out_char, out_last_char);
        err_count++;
      end else begin
        want = expected_chars.pop_front();
        if (out_char !== want.ch) begin
          $error("out_char: expected %h, actual %h", want.ch, out_char);
          err_count++;
        end
        if (out_last_char !== want.last) begin
          $error("out_last_char: expected %b, actual %b", want.last, out_last_char);
          err_count++;
        end
      end
    end
  end

  // Watchdog: ends the run when no transfer happens for too long.
  always @(posedge clk) begin
    if (!rst_n || (start && !busy) || out_strobe) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    repeat (9) @(negedge clk);
    rst_n <= 1'b1;
    test_directed_cases();
    test_drain_pause();
    test_random_traffic(RANDOM_ITEMS);
    wait_all_received();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (expected_chars.size() != 0) begin
      $error("%0d expected characters never arrived", expected_chars.size());
      err_count++;
    end
    if (err_count == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

### filelist.f
hdl/hff_pkg.sv
hdl/hff_layout.sv
hdl/hex_field_formatter_unit.sv
hdl/hff_checker.sv
tb/tb_hex_field_formatter_unit.sv
